>>> design/sqrs_pkg.sv
// Shared types and constants for the square-root radical simplifier.
package sqrs_pkg;

  localparam int OUTER_W  = 16;
  localparam int INNER_W  = 31;
  localparam int ROOT_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_POSITIVE = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NEGATIVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_DIV,
    S_STEP,
    S_FINAL,
    S_OUT
  } state_t;

endpackage

>>> design/square_root_radical_simplifier_core.sv
// Top level of the square-root radical simplifier: trial-division factoring and fixed-point root.
//
//  Channel | Signals                                            | Direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid, in_ready, value                          | in
//  output  | out_valid, out_ready, outer_factor, inner_factor,  | out
//          | root_fixed, status                                 |
//
// A zero or negative request goes from idle straight to the output state.
// A positive request runs the bit-serial root, then trial divisions on the one
// shared restoring divider; there is one division per prime factor counted
// with multiplicity, plus one per candidate divisor (two, then the odd
// numbers) until the candidate exceeds the square root of what is left, so a
// product of two large primes is the slowest case.
// Reset returns the sequencer to idle and drops out_valid.
// A result held by out_ready low stalls only the final load; a new request is
// taken while the previous result still waits.
module square_root_radical_simplifier_core
  import sqrs_pkg::*;
#(
  parameter int VALUE_BITS     = 32,
  parameter int ROOT_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUTER_W-1:0]    outer_factor,
  output logic [INNER_W-1:0]    inner_factor,
  output logic [ROOT_W-1:0]     root_fixed,
  output logic [STATUS_W-1:0]   status
);

  localparam int RW       = VALUE_BITS - 1;
  localparam int HALF     = (VALUE_BITS + 1) / 2;
  localparam int RTW      = HALF + ROOT_FRAC_BITS;
  localparam int RMW      = RTW + 2;
  localparam int ITER_MAX = (RTW > RW) ? RTW : RW;
  localparam int CNT_W    = $clog2(ITER_MAX);

  state_t               state, state_next;
  logic                 out_valid_next;
  logic [2*HALF-1:0]    nsh, nsh_next;
  logic [RTW-1:0]       root, root_next;
  logic [RMW-1:0]       rrem, rrem_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [RW-1:0]        rest, rest_next;
  logic [RW-1:0]        p, p_next;
  logic [RW-1:0]        dq, dq_next;
  logic [RW-1:0]        drem, drem_next;
  logic [OUTER_W-1:0]   outer, outer_next;
  logic [INNER_W-1:0]   inner, inner_next;
  logic                 odd, odd_next;
  logic                 in_inner, in_inner_next;
  status_t              res_status, res_status_next;
  logic [OUTER_W-1:0]   outer_factor_next;
  logic [INNER_W-1:0]   inner_factor_next;
  logic [ROOT_W-1:0]    root_fixed_next;
  logic [STATUS_W-1:0]  status_next;

  logic [RMW-1:0]       rsh;
  logic [RMW-1:0]       rtrial;
  logic [RW:0]          dsh;
  logic                 dfit;
  logic                 is_neg;

  assign is_neg = value[VALUE_BITS-1];
  assign rsh    = {rrem[RMW-3:0], nsh[2*HALF-1 -: 2]};
  assign rtrial = {root, 2'b01};
  assign dsh    = {drem, dq[RW-1]};
  assign dfit   = dsh >= {1'b0, p};

  always_comb begin
    state_next        = state;
    out_valid_next    = out_valid;
    nsh_next          = nsh;
    root_next         = root;
    rrem_next         = rrem;
    cnt_next          = cnt;
    rest_next         = rest;
    p_next            = p;
    dq_next           = dq;
    drem_next         = drem;
    outer_next        = outer;
    inner_next        = inner;
    odd_next          = odd;
    in_inner_next     = in_inner;
    res_status_next   = res_status;
    outer_factor_next = outer_factor;
    inner_factor_next = inner_factor;
    root_fixed_next   = root_fixed;
    status_next       = status;
    in_ready          = 1'b0;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          root_next  = '0;
          rrem_next  = '0;
          nsh_next   = (2*HALF)'(value);
          rest_next  = value[RW-1:0];
          cnt_next   = CNT_W'(RTW - 1);
          outer_next = '0;
          inner_next = '0;
          if (value == '0) begin
            res_status_next = ST_ZERO;
            state_next      = S_OUT;
          end else if (is_neg) begin
            res_status_next = ST_NEGATIVE;
            state_next      = S_OUT;
          end else begin
            res_status_next = ST_POSITIVE;
            state_next      = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        nsh_next = nsh << 2;
        if (rsh >= rtrial) begin
          rrem_next = rsh - rtrial;
          root_next = {root[RTW-2:0], 1'b1};
        end else begin
          rrem_next = rsh;
          root_next = {root[RTW-2:0], 1'b0};
        end
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          p_next        = RW'(2);
          outer_next    = OUTER_W'(1);
          inner_next    = INNER_W'(1);
          odd_next      = 1'b0;
          in_inner_next = 1'b0;
          dq_next       = rest;
          drem_next     = '0;
          cnt_next      = CNT_W'(RW - 1);
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (dfit) begin
          drem_next = RW'(dsh - {1'b0, p});
          dq_next   = {dq[RW-2:0], 1'b1};
        end else begin
          drem_next = dsh[RW-1:0];
          dq_next   = {dq[RW-2:0], 1'b0};
        end
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        drem_next  = '0;
        cnt_next   = CNT_W'(RW - 1);
        state_next = S_DIV;
        if (!in_inner && (p > dq)) begin
          state_next = S_FINAL;
        end else if (drem == '0) begin
          rest_next     = dq;
          odd_next      = ~odd;
          in_inner_next = 1'b1;
          if (odd) begin
            outer_next = OUTER_W'(outer * OUTER_W'(p));
          end
        end else begin
          if (odd) begin
            inner_next = INNER_W'(inner * INNER_W'(p));
          end
          p_next        = (p == RW'(2)) ? RW'(3) : p + RW'(2);
          odd_next      = 1'b0;
          in_inner_next = 1'b0;
          dq_next       = rest;
        end
      end
      S_FINAL: begin
        if (rest > RW'(1)) begin
          inner_next = INNER_W'(inner * INNER_W'(rest));
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          outer_factor_next = outer;
          inner_factor_next = inner;
          root_fixed_next   = ROOT_W'(root);
          status_next       = res_status;
          out_valid_next    = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    nsh          <= nsh_next;
    root         <= root_next;
    rrem         <= rrem_next;
    cnt          <= cnt_next;
    rest         <= rest_next;
    p            <= p_next;
    dq           <= dq_next;
    drem         <= drem_next;
    outer        <= outer_next;
    inner        <= inner_next;
    odd          <= odd_next;
    in_inner     <= in_inner_next;
    res_status   <= res_status_next;
    outer_factor <= outer_factor_next;
    inner_factor <= inner_factor_next;
    root_fixed   <= root_fixed_next;
    status       <= status_next;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("accepted request did not start the sequencer");

  a_special_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_POSITIVE) |->
      (outer_factor == '0) && (inner_factor == '0) && (root_fixed == '0))
    else $error("zero or negative result carries nonzero fields");

  a_divisor_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_STEP) |-> p >= RW'(2))
    else $error("trial divisor below two");

  a_remainder_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |-> drem < p)
    else $error("divider remainder not below divisor");

  a_out_load_from_out_state: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

endmodule

>>> test/square_root_radical_simplifier_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the radical simplifier core: directed table and random requests.
module square_root_radical_simplifier_core_tb;
  import sqrs_pkg::*;

  typedef struct {
    logic [OUTER_W-1:0] outer;
    logic [INNER_W-1:0] inner;
    logic [ROOT_W-1:0]  root;
    status_t            st;
  } radical_t;

  typedef struct {
    logic [31:0] value;
    bit          fixed;
    radical_t    want;
  } request_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUTER_W-1:0] outer_factor;
  logic [INNER_W-1:0] inner_factor;
  logic [ROOT_W-1:0] root_fixed;
  logic [STATUS_W-1:0] status;

  request_row_t requests [$];
  radical_t pending_radicals [$];
  bit steady = 1'b0;
  int directed_count = 0;
  int sent = 0;
  int checked = 0;
  int mismatches = 0;
  int status_seen [3] = '{0, 0, 0};

  square_root_radical_simplifier_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .outer_factor(outer_factor),
    .inner_factor(inner_factor),
    .root_fixed(root_fixed),
    .status(status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic radical_t radical_of(input logic [31:0] v);
    radical_t r;
    longint unsigned rest, outer, inner, p, x, rem, root, trial;
    int unsigned count;
    r.outer = '0;
    r.inner = '0;
    r.root = '0;
    if (v == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    if (v[31]) begin
      r.st = ST_NEGATIVE;
      return r;
    end
    rest = v;
    outer = 1;
    inner = 1;
    for (p = 2; p <= rest / p; p++) begin
      count = 0;
      while (rest % p == 0) begin
        rest = rest / p;
        count++;
        if (count % 2 == 0) outer = outer * p;
      end
      if (count % 2 == 1) inner = inner * p;
    end
    if (rest > 1) inner = inner * rest;
    // Integer square root of v scaled by 2^32, two bits of the radicand per step.
    x = {v, 32'd0};
    rem = 0;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      rem = (rem << 2) | ((x >> (2 * k)) & 64'd3);
      trial = (root << 2) | 64'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    r.outer = outer[OUTER_W-1:0];
    r.inner = inner[INNER_W-1:0];
    r.root = root[ROOT_W-1:0];
    r.st = ST_POSITIVE;
    return r;
  endfunction

  function automatic void add_row(input logic [31:0] v, input bit fixed, input radical_t want);
    request_row_t row;
    row.value = v;
    row.fixed = fixed;
    row.want = want;
    requests.push_back(row);
  endfunction

  function automatic logic [31:0] random_value();
    longint unsigned r;
    longint unsigned f;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 15) return $urandom | 32'h8000_0000;
    if (kind < 20) return $urandom_range(0, 1);
    if (kind < 60) begin
      // Smooth numbers reach the upper bits while trial division stays short.
      r = 1;
      repeat ($urandom_range(1, 24)) begin
        f = $urandom_range(2, 97);
        if (r * f <= 64'h7FFF_FFFF) r = r * f;
      end
      return r[31:0];
    end
    if (kind < 92) return $urandom_range(2, 4095);
    return $urandom_range(4096, 1 << 18);
  endfunction

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    radical_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_radicals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result: outer %0d inner %0d root %0d status %0d",
                   outer_factor, inner_factor, root_fixed, status);
      end else begin
        w = pending_radicals.pop_front();
        checked++;
        if (status < 3) status_seen[status]++;
        if (outer_factor !== w.outer || inner_factor !== w.inner ||
            root_fixed !== w.root || status !== w.st) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d: expected outer %0d inner %0d root %0d status %0d,",
                     checked, w.outer, w.inner, w.root, w.st);
            $display("       got outer %0d inner %0d root %0d status %0d",
                     outer_factor, inner_factor, root_fixed, status);
          end
        end
      end
    end
  end

  initial begin
    int idx;
    int stretch_lo;
    request_row_t row;
    add_row(32'd0, 1'b1, '{16'd0, 31'd0, 32'd0, ST_ZERO});
    add_row(32'hFFFF_FFFF, 1'b1, '{16'd0, 31'd0, 32'd0, ST_NEGATIVE});
    add_row(32'h8000_0000, 1'b1, '{16'd0, 31'd0, 32'd0, ST_NEGATIVE});
    add_row(32'd1, 1'b1, '{16'd1, 31'd1, 32'd65536, ST_POSITIVE});
    add_row(32'd4, 1'b1, '{16'd2, 31'd1, 32'd131072, ST_POSITIVE});
    add_row(32'h4000_0000, 1'b1, '{16'd32768, 31'd1, 32'h8000_0000, ST_POSITIVE});
    add_row(32'd2147395600, 1'b1, '{16'd46340, 31'd1, 32'd3036938240, ST_POSITIVE});
    add_row(32'd2, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'd3, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'd12, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'd72, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'd97, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'd360, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'd1024, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'd65535, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'd2147483646, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'h7FFF_0000, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'h5555_5555, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'h2AAA_AAAA, 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});
    add_row(32'h8000_0001, 1'b1, '{16'd0, 31'd0, 32'd0, ST_NEGATIVE});
    directed_count = requests.size();
    repeat (80) add_row(random_value(), 1'b0, '{16'd0, 31'd0, 32'd0, ST_POSITIVE});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    stretch_lo = directed_count + 40;
    idx = 0;
    while (idx < requests.size()) begin
      steady = (idx >= stretch_lo) && (idx < stretch_lo + 30);
      if (!steady && $urandom_range(0, 99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        row = requests[idx];
        in_valid <= 1'b1;
        value <= row.value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_radicals.push_back(row.fixed ? row.want : radical_of(row.value));
        sent++;
        idx++;
      end
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (pending_radicals.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d requests (%0d from the directed table), checked %0d results.",
             sent, directed_count, checked);
    $display("Results by status: positive %0d, zero %0d, negative %0d; mismatches %0d.",
             status_seen[0], status_seen[1], status_seen[2], mismatches);
    if (mismatches == 0 && pending_radicals.size() == 0) begin
      $display("PASS square_root_radical_simplifier_core");
    end else begin
      $display("FAIL square_root_radical_simplifier_core");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL square_root_radical_simplifier_core");
    $finish;
  end

endmodule
